// ===== hdl/lnps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the last-note priority stack.
// Used by lnps_cell and last_note_priority_stack; no dependencies.
package lnps_pkg;

  localparam int NoteW         = 7;
  localparam int OpW           = 3;
  localparam int TimeW         = 16;
  localparam int HeldCountW    = 4;
  localparam int StackDepthDef = 10;

  localparam logic [TimeW-1:0] TimeoutReset = 16'd5000;
  localparam logic [TimeW-1:0] SilenceMax   = 16'hFFFF;

  typedef enum logic [OpW-1:0] {
    OpNoteOn    = 3'd0,
    OpNoteOff   = 3'd1,
    OpAllOff    = 3'd2,
    OpHeartbeat = 3'd3,
    OpTick      = 3'd4
  } op_e;

  // Per-beat command broadcast to every cell of the row.
  typedef struct packed {
    logic             remove_en;   // drop the first matching entry
    logic             push_en;     // write the note at the placement slot
    logic             full_shift;  // shift the whole row down, note enters on top
    logic [NoteW-1:0] note;
  } cell_ctrl_t;

endpackage

// ===== hdl/lnps_cell.sv =====
`timescale 1ns / 1ps
// One slot of the note stack: holds a note, matches it, shifts from its upper neighbor.
// Depends on lnps_pkg.
module lnps_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 4
) (
  input  logic                        clk_i,
  input  lnps_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [CNT_W-1:0]            place_i,
  input  logic [lnps_pkg::NoteW-1:0]  upper_note_i,
  input  logic                        found_below_i,
  output logic                        found_o,
  output logic [lnps_pkg::NoteW-1:0]  note_o,
  output logic [lnps_pkg::NoteW-1:0]  next_note_o
);

  logic [lnps_pkg::NoteW-1:0] note_q, note_d;
  logic in_use, match, shift, put_here;

  assign in_use   = CNT_W'(INDEX) < count_i;
  assign match    = in_use && (note_q == ctrl_i.note);
  assign found_o  = found_below_i || match;
  // Everything at or above the first match moves down one slot.
  assign shift    = (ctrl_i.remove_en && found_o) || ctrl_i.full_shift;
  assign put_here = ctrl_i.push_en && !ctrl_i.full_shift && (place_i == CNT_W'(INDEX));

  always_comb begin
    note_d = note_q;
    if (put_here) begin
      note_d = ctrl_i.note;
    end else if (shift) begin
      note_d = upper_note_i;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

  assign note_o      = note_q;
  assign next_note_o = note_d;

endmodule

// ===== hdl/last_note_priority_stack.sv =====
`timescale 1ns / 1ps
// Top level of the last-note priority stack: a row of lnps_cell slots plus
// count, silence counter, timeout register and result register. Depends on lnps_pkg.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  in        in_valid_i/in_ready_o   op_i, note_i
//  out       out_valid_o/out_ready_i gate_o, current_note_o, note_valid_o,
//                                    held_count_o
//  cfg       cfg_valid_i/cfg_ready_o cfg_data_i (silence timeout)
//
// Each beat completes at the edge that accepts it: the cells compare, shift and place in
// parallel and the result register loads at the same edge; the result shows
// in the cycle after acceptance. The input is taken whenever the result register
// is empty or being drained, so a beat can be accepted every cycle.
// Reset empties the stack, clears the silence counter and loads timeout 5000.
// Cell contents are not reset; slots above the held count are never reported.
// A stalled output holds its result and blocks further input beats.
module last_note_priority_stack #(
  parameter int STACK_DEPTH = lnps_pkg::StackDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beats
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lnps_pkg::OpW-1:0]          op_i,
  input  logic [lnps_pkg::NoteW-1:0]        note_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              gate_o,
  output logic [lnps_pkg::NoteW-1:0]        current_note_o,
  output logic                              note_valid_o,
  output logic [lnps_pkg::HeldCountW-1:0]   held_count_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lnps_pkg::TimeW-1:0]        cfg_data_i
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int HcW  = lnps_pkg::HeldCountW;
  localparam int NW   = lnps_pkg::NoteW;

  // Control and counters
  logic [CntW-1:0]               count_q, count_d;
  logic [lnps_pkg::TimeW-1:0]    silence_q, silence_d;
  logic [lnps_pkg::TimeW-1:0]    timeout_q;
  logic [lnps_pkg::TimeW-1:0]    silence_inc;
  logic                          in_fire, any_found, is_full;
  logic [CntW-1:0]               cnt_after;
  lnps_pkg::cell_ctrl_t          ctrl;

  // Result register
  logic                          out_valid_q;
  logic                          gate_q, note_valid_q;
  logic [NW-1:0]                 current_note_q, current_note_d;
  logic [HcW-1:0]                held_count_q;
  logic [IdxW-1:0]               top_idx;

  // Cell row wiring
  logic [STACK_DEPTH:0]          found;
  logic [NW-1:0]                 cell_note [STACK_DEPTH];
  logic [NW-1:0]                 next_note [STACK_DEPTH];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Build the per-beat command; only an accepted note on/off touches the row.
  assign is_full   = (count_q == CntW'(STACK_DEPTH));
  assign any_found = found[STACK_DEPTH];
  assign cnt_after = count_q - CntW'(any_found);

  always_comb begin
    ctrl.remove_en  = 1'b0;
    ctrl.push_en    = 1'b0;
    ctrl.full_shift = 1'b0;
    ctrl.note       = note_i;
    if (in_fire) begin
      if (op_i == lnps_pkg::OpNoteOn) begin
        ctrl.remove_en  = 1'b1;
        ctrl.push_en    = 1'b1;
        // Full and not a re-press: drop the oldest note.
        ctrl.full_shift = is_full && !any_found;
      end else if (op_i == lnps_pkg::OpNoteOff) begin
        ctrl.remove_en = 1'b1;
      end
    end
  end

  // Row of cells, oldest at index 0; the top cell's upper input is the new note.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [NW-1:0] upper;
    if (i == STACK_DEPTH - 1) begin : g_top
      assign upper = ctrl.note;
    end else begin : g_mid
      assign upper = cell_note[i+1];
    end
    lnps_cell #(
      .INDEX (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .place_i       (cnt_after),
      .upper_note_i  (upper),
      .found_below_i (found[i]),
      .found_o       (found[i+1]),
      .note_o        (cell_note[i]),
      .next_note_o   (next_note[i])
    );
  end

  // Advance the silence counter, saturating.
  assign silence_inc = (silence_q == lnps_pkg::SilenceMax) ? silence_q
                                                           : silence_q + 1'b1;

  always_comb begin
    count_d   = count_q;
    silence_d = silence_q;
    if (in_fire) begin
      unique case (op_i)
        lnps_pkg::OpNoteOn: begin
          count_d   = (is_full && !any_found) ? count_q : cnt_after + 1'b1;
          silence_d = '0;
        end
        lnps_pkg::OpNoteOff: begin
          count_d   = cnt_after;
          silence_d = '0;
        end
        lnps_pkg::OpAllOff: begin
          count_d   = '0;
          silence_d = '0;
        end
        lnps_pkg::OpHeartbeat: begin
          silence_d = '0;
        end
        lnps_pkg::OpTick: begin
          // Release everything once held notes have been silent too long.
          if (count_q != '0 && silence_inc > timeout_q) begin
            count_d   = '0;
            silence_d = '0;
          end else begin
            silence_d = silence_inc;
          end
        end
        default: begin
          // unused codes: hold state
        end
      endcase
    end
  end

  // Top of stack after this beat.
  assign top_idx        = IdxW'(count_d - 1'b1);
  assign current_note_d = (count_d != '0) ? next_note[top_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      silence_q   <= '0;
      timeout_q   <= lnps_pkg::TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      silence_q <= silence_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gate_q         <= (count_d != '0);
      note_valid_q   <= (count_d != '0);
      current_note_q <= current_note_d;
      held_count_q   <= HcW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gate_o         = gate_q;
  assign note_valid_o   = note_valid_q;
  assign current_note_o = current_note_q;
  assign held_count_o   = held_count_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  a_note_on_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == lnps_pkg::OpNoteOn) |=>
      (note_valid_o && current_note_o == $past(note_i)))
    else $error("pressed note is not on top");

  a_all_off_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == lnps_pkg::OpAllOff) |=> (count_q == '0 && !gate_o))
    else $error("all off left notes held");

  a_activity_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == lnps_pkg::OpNoteOff || op_i == lnps_pkg::OpHeartbeat))
      |=> (silence_q == '0))
    else $error("silence counter not restarted");

  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (gate_q == note_valid_q && ((STACK_DEPTH > 15) ||
                     gate_q == (held_count_q != '0))))
    else $error("result fields disagree");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for last_note_priority_stack: a queue-fed driver, a
// monitor with its own note-stack predictor, and a stall watchdog. Depends on lnps_pkg.
module testbench;

  localparam int Depth        = lnps_pkg::StackDepthDef;
  localparam int NoteW        = lnps_pkg::NoteW;
  localparam int OpW          = lnps_pkg::OpW;
  localparam int TimeW        = lnps_pkg::TimeW;
  localparam int HeldCountW   = lnps_pkg::HeldCountW;
  localparam int NoteMax      = (1 << NoteW) - 1;
  localparam int OpCodeMax    = (1 << OpW) - 1;
  localparam int PoolSpan     = 12;
  localparam int SettleCycles = 4;
  localparam int StallLimit   = 2000;
  localparam int Segments     = 15;
  localparam int SegmentItems = 110;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [NoteW-1:0] note;
  } note_event_t;

  typedef struct packed {
    logic                  gate;
    logic [NoteW-1:0]      note;
    logic                  valid;
    logic [HeldCountW-1:0] count;
  } note_status_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [OpW-1:0]        op_i           = '0;
  logic [NoteW-1:0]      note_i         = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  gate_o;
  logic [NoteW-1:0]      current_note_o;
  logic                  note_valid_o;
  logic [HeldCountW-1:0] held_count_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [TimeW-1:0]      cfg_data_i     = '0;

  // Beats waiting for the driver, and status beats the predictor owes.
  note_event_t  event_queue[$];
  note_status_t status_due[$];
  note_event_t  launch_event;
  int           beats_queued   = 0;
  int           beats_taken    = 0;
  int           results_seen   = 0;
  int           error_count    = 0;
  int           send_gap_pct   = 0;
  int           sink_stall_pct = 0;
  logic         in_beat_taken  = 1'b0;
  logic         cfg_beat_taken = 1'b0;

  // Predictor state: held notes oldest first, silence counter, timeout register.
  logic [NoteW-1:0] held_stack [Depth];
  int               held_total    = 0;
  logic [TimeW-1:0] quiet_ticks   = '0;
  logic [TimeW-1:0] release_limit = lnps_pkg::TimeoutReset;

  logic [TimeW-1:0] timeout_plan [Segments] = '{
    16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd5, 16'd3, 16'hFFFE, 16'd10,
    16'd1, 16'd0, 16'd7, 16'd4, lnps_pkg::TimeoutReset, 16'd20, 16'hFFFF
  };

  last_note_priority_stack #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .note_i        (note_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .gate_o        (gate_o),
    .current_note_o(current_note_o),
    .note_valid_o  (note_valid_o),
    .held_count_o  (held_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Remove the first copy of a note and close the gap above it.
  function automatic void drop_note(input logic [NoteW-1:0] n);
    for (int i = 0; i < held_total; i++) begin
      if (held_stack[i] == n) begin
        for (int j = i; j + 1 < held_total; j++) held_stack[j] = held_stack[j + 1];
        held_total--;
        return;
      end
    end
  endfunction

  // Advance the predictor by one beat and return the status it must produce.
  function automatic note_status_t play_event(input logic [OpW-1:0] op,
                                              input logic [NoteW-1:0] n);
    note_status_t st;
    case (op)
      lnps_pkg::OpNoteOn: begin
        drop_note(n);
        // Full stack: shift out the oldest note to make room on top.
        if (held_total >= Depth) begin
          for (int j = 0; j + 1 < Depth; j++) held_stack[j] = held_stack[j + 1];
          held_total = Depth - 1;
        end
        held_stack[held_total] = n;
        held_total++;
        quiet_ticks = '0;
      end
      lnps_pkg::OpNoteOff: begin
        drop_note(n);
        quiet_ticks = '0;
      end
      lnps_pkg::OpAllOff: begin
        held_total  = 0;
        quiet_ticks = '0;
      end
      lnps_pkg::OpHeartbeat: begin
        quiet_ticks = '0;
      end
      lnps_pkg::OpTick: begin
        // Count first, then compare; a release behaves like all off.
        if (quiet_ticks != lnps_pkg::SilenceMax) quiet_ticks++;
        if (held_total != 0 && quiet_ticks > release_limit) begin
          held_total  = 0;
          quiet_ticks = '0;
        end
      end
      default: begin
        // spare op codes leave everything alone
      end
    endcase
    st.gate  = (held_total != 0);
    st.valid = (held_total != 0);
    st.note  = (held_total != 0) ? held_stack[held_total - 1] : '0;
    st.count = held_total[HeldCountW-1:0];
    return st;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, what);
  endtask

  task automatic queue_event(input logic [OpW-1:0] op, input logic [NoteW-1:0] n);
    note_event_t ev;
    ev.op   = op;
    ev.note = n;
    event_queue.push_back(ev);
    beats_queued++;
  endtask

  // Hold the sender until every beat is taken and every status has come back.
  task automatic drain_stack;
    do @(negedge clk_i); while (beats_taken != beats_queued || status_due.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TimeW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_beat_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly notes from a narrow pool so re-presses and matching releases happen.
  function automatic logic [NoteW-1:0] pick_note(input int pool_base);
    if ($urandom_range(99) < 75) return NoteW'(pool_base + $urandom_range(PoolSpan - 1));
    return NoteW'($urandom_range(NoteMax));
  endfunction

  // Queue a run of musically shaped beats; tick bursts are sized to a short timeout
  // (and capped for a long one) so that releases by silence actually occur.
  task automatic queue_random_run(input int budget, input logic [TimeW-1:0] timeout);
    int placed;
    int roll;
    int burst;
    int tick_burst;
    int pool_base;
    placed     = 0;
    pool_base  = $urandom_range(NoteMax - PoolSpan + 1);
    tick_burst = (timeout < 28) ? int'(timeout) + 3 : 30;
    while (placed < budget) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        queue_event(lnps_pkg::OpNoteOn, pick_note(pool_base));
        placed++;
      end else if (roll < 36) begin
        // chord run, at times long enough to overflow the stack
        burst = $urandom_range(Depth + 4, 4);
        repeat (burst) queue_event(lnps_pkg::OpNoteOn, pick_note(pool_base));
        placed += burst;
      end else if (roll < 54) begin
        queue_event(lnps_pkg::OpNoteOff, pick_note(pool_base));
        placed++;
      end else if (roll < 78) begin
        burst = $urandom_range(tick_burst, 1);
        repeat (burst) queue_event(lnps_pkg::OpTick, NoteW'($urandom_range(NoteMax)));
        placed += burst;
      end else if (roll < 86) begin
        queue_event(lnps_pkg::OpHeartbeat, NoteW'($urandom_range(NoteMax)));
        placed++;
      end else if (roll < 91) begin
        queue_event(lnps_pkg::OpAllOff, NoteW'($urandom_range(NoteMax)));
        placed++;
      end else if (roll < 96) begin
        // stray release, usually for a note nobody holds
        queue_event(lnps_pkg::OpNoteOff, NoteW'($urandom_range(NoteMax)));
        placed++;
      end else begin
        // spare op codes are no-ops; they do not count toward the budget
        queue_event(OpW'($urandom_range(OpCodeMax, int'(lnps_pkg::OpTick) + 1)),
                    NoteW'($urandom_range(NoteMax)));
      end
    end
  endtask

  // Driver: present a beat at the falling edge; hold it until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_beat_taken) begin
      // hold valid and payload
    end else if (event_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
      launch_event = event_queue.pop_front();
      in_valid_i <= 1'b1;
      op_i       <= launch_event.op;
      note_i     <= launch_event.note;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result sink: stall at random, also during reset.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: check the result beat first, then predict for the input beat
  // taken at this same edge (its status can only show up later).
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_beat_taken  = 1'b0;
      cfg_beat_taken = 1'b0;
      held_total     = 0;
      quiet_ticks    = '0;
      release_limit  = lnps_pkg::TimeoutReset;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (status_due.size() == 0) begin
          report_mismatch("status beat with nothing outstanding");
        end else begin
          note_status_t want;
          want = status_due.pop_front();
          if (gate_o !== want.gate)
            report_mismatch($sformatf("gate %0b, want %0b", gate_o, want.gate));
          if (current_note_o !== want.note)
            report_mismatch($sformatf("current_note %0d, want %0d", current_note_o,
                                      want.note));
          if (note_valid_o !== want.valid)
            report_mismatch($sformatf("note_valid %0b, want %0b", note_valid_o,
                                      want.valid));
          if (held_count_o !== want.count)
            report_mismatch($sformatf("held_count %0d, want %0d", held_count_o,
                                      want.count));
        end
        results_seen++;
      end
      in_beat_taken = in_valid_i && in_ready_o;
      if (in_beat_taken) begin
        status_due.push_back(play_event(op_i, note_i));
        beats_taken++;
      end
      cfg_beat_taken = cfg_valid_i && cfg_ready_o;
      if (cfg_beat_taken) release_limit = cfg_data_i;
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [TimeW-1:0] timeout;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    send_gap_pct   = 11;
    sink_stall_pct = 79;

    // Directed: reset state, re-press at top and bottom, stray and real
    // releases, overflow of a full stack, spare op codes, all off.
    queue_event(OpW'(int'(lnps_pkg::OpTick) + 1), 7'd127);
    queue_event(lnps_pkg::OpHeartbeat, 7'd0);
    queue_event(lnps_pkg::OpTick, 7'd0);
    queue_event(lnps_pkg::OpNoteOn, 7'd0);
    queue_event(lnps_pkg::OpNoteOn, 7'd127);
    queue_event(lnps_pkg::OpNoteOn, 7'd127);
    queue_event(lnps_pkg::OpNoteOn, 7'd0);
    queue_event(lnps_pkg::OpNoteOff, 7'd5);
    queue_event(lnps_pkg::OpNoteOff, 7'd127);
    for (int n = 1; n <= Depth; n++) queue_event(lnps_pkg::OpNoteOn, NoteW'(n));
    queue_event(lnps_pkg::OpNoteOn, 7'd5);
    queue_event(lnps_pkg::OpNoteOff, 7'd5);
    queue_event(OpW'(OpCodeMax), 7'd127);
    queue_event(lnps_pkg::OpAllOff, 7'd0);
    drain_stack();

    // Zero timeout releases on the first tick; a timeout of one on the second.
    write_timeout('0);
    queue_event(lnps_pkg::OpNoteOn, 7'd64);
    queue_event(lnps_pkg::OpTick, 7'd0);
    drain_stack();
    write_timeout(16'd1);
    queue_event(lnps_pkg::OpNoteOn, 7'd42);
    queue_event(lnps_pkg::OpTick, 7'd0);
    queue_event(lnps_pkg::OpTick, 7'd0);
    drain_stack();

    // Random segments: receiver sparse then sender sparse, then full rate.
    // Each segment boundary drains completely before the register changes.
    for (int seg = 0; seg < Segments; seg++) begin
      if (seg < 5) begin
        send_gap_pct   = 11;
        sink_stall_pct = 79;
      end else if (seg < 10) begin
        send_gap_pct   = 79;
        sink_stall_pct = 11;
      end else begin
        send_gap_pct   = 0;
        sink_stall_pct = 0;
      end
      timeout = timeout_plan[seg];
      write_timeout(timeout);
      queue_random_run(SegmentItems, timeout);
      drain_stack();
    end

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== last_note_priority_stack.f =====
hdl/lnps_pkg.sv
hdl/lnps_cell.sv
hdl/last_note_priority_stack.sv
sim/testbench.sv
